// ===== hdl/base64_stream_decoder_assert.svh =====
// Assertion macros shared by the decoder modules.
// Each macro expects clk and arst_n in scope.
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define B64D_ASSERT_NOW(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("b64d assertion failed");

// Next-cycle implication.
`define B64D_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("b64d assertion failed");

`endif

// ===== hdl/b64d_pkg.sv =====
package b64d_pkg;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_PAD     = 8'h3D;

	localparam logic [5:0] SX_LOWER_BASE = 6'd26;
	localparam logic [5:0] SX_DIGIT_BASE = 6'd52;
	localparam logic [5:0] SX_PLUS       = 6'd62;
	localparam logic [5:0] SX_SLASH      = 6'd63;

	// Result bundle of one character: up to three bytes plus an optional status.
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
		logic        status;
		logic        bad;
	} b64d_burst_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} b64d_sextet_t;

	function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
		b64d_sextet_t r;
		r.valid = 1'b1;
		r.value = 6'd0;
		priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			r.value = 6'(c - CH_UPPER_A);
		else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			r.value = 6'(c - CH_LOWER_A) + SX_LOWER_BASE;
		else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
			r.value = 6'(c - CH_DIGIT_0) + SX_DIGIT_BASE;
		else if (c == CH_PLUS)
			r.value = SX_PLUS;
		else if (c == CH_SLASH)
			r.value = SX_SLASH;
		else
			r.valid = 1'b0;
		return r;
	endfunction

endpackage

// ===== hdl/b64d_quartet.sv =====
`include "base64_stream_decoder_assert.svh"

module b64d_quartet import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  text_char,
	input  logic        final_char,
	output b64d_burst_t burst
);

	logic [1:0]  pos_q;
	logic [17:0] buf_q;
	logic [1:0]  pad_q;
	logic        closed_q;
	logic        err_q;

	logic [1:0]  pos_n;
	logic [17:0] buf_n;
	logic [1:0]  pad_n;
	logic        closed_n;
	logic        err_n;

	always_comb begin
		b64d_sextet_t sx;
		logic [5:0]   v;
		logic         e;
		sx = sextet_of(text_char);
		v = 6'd0;
		e = 1'b0;
		pos_n = pos_q + 2'd1;
		buf_n = buf_q;
		pad_n = pad_q;
		closed_n = closed_q;
		err_n = err_q;
		burst.word = {buf_q, 6'd0};
		burst.nbytes = 2'd0;
		burst.status = 1'b0;
		burst.bad = 1'b0;
		if (!err_q) begin
			if (closed_q)
				e = 1'b1;
			else if (text_char == CH_PAD) begin
				if (pos_q < 2'd2)
					e = 1'b1;
				else
					pad_n = pad_q + 2'd1;
			end else begin
				if (!sx.valid || pad_q != 2'd0)
					e = 1'b1;
				else
					v = sx.value;
			end
			if (!e) begin
				if (pos_q != 2'd3)
					buf_n = {buf_q[11:0], v};
				else begin
					burst.word = {buf_q, v};
					unique case (pad_n)
						2'd0:    burst.nbytes = 2'd3;
						2'd1:    burst.nbytes = 2'd2;
						default: burst.nbytes = 2'd1;
					endcase
					if (pad_n != 2'd0)
						closed_n = 1'b1;
					pad_n = 2'd0;
					buf_n = 18'd0;
				end
			end
			err_n = e;
		end
		// End of text: report status and return to the reset state.
		if (final_char) begin
			burst.status = 1'b1;
			burst.bad = err_n | (pos_q != 2'd3);
			pos_n = 2'd0;
			buf_n = 18'd0;
			pad_n = 2'd0;
			closed_n = 1'b0;
			err_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0;
			buf_q <= 18'd0;
			pad_q <= 2'd0;
			closed_q <= 1'b0;
			err_q <= 1'b0;
		end else if (step) begin
			pos_q <= pos_n;
			buf_q <= buf_n;
			pad_q <= pad_n;
			closed_q <= closed_n;
			err_q <= err_n;
		end
	end

	`B64D_ASSERT_NOW(a_no_bytes_after_error, err_q, burst.nbytes == 2'd0)
	`B64D_ASSERT_NEXT(a_final_clears, step && final_char, pos_q == 2'd0 && !err_q && !closed_q)
	`B64D_ASSERT_NOW(a_pad_only_late, pad_q != 2'd0 && !err_q, pos_q == 2'd3 || pos_q == 2'd0)

endmodule

// ===== hdl/b64d_emit.sv =====
`include "base64_stream_decoder_assert.svh"

module b64d_emit import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  b64d_burst_t burst,
	output logic        can_load,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	output logic [1:0]  m_axis_tuser,
	output logic        m_axis_tlast
);

	logic [23:0] word_q;
	logic [1:0]  nbytes_q;
	logic        stat_q;
	logic        bad_q;
	logic [2:0]  total;
	logic        take;

	assign total = {1'b0, nbytes_q} + {2'b00, stat_q};
	assign take = m_axis_tvalid && m_axis_tready;
	// Free, or the last pending result leaves this cycle.
	assign can_load = (total == 3'd0) || (total == 3'd1 && m_axis_tready);

	assign m_axis_tvalid = total != 3'd0;
	assign m_axis_tlast = total == 3'd1;
	assign m_axis_tdata = (nbytes_q != 2'd0) ? word_q[23:16] : 8'd0;
	assign m_axis_tuser = (nbytes_q != 2'd0) ? 2'b00 : {bad_q, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbytes_q <= 2'd0;
			stat_q <= 1'b0;
			bad_q <= 1'b0;
		end else if (load && can_load) begin
			nbytes_q <= burst.nbytes;
			stat_q <= burst.status;
			bad_q <= burst.bad;
		end else if (take) begin
			if (nbytes_q != 2'd0)
				nbytes_q <= nbytes_q - 2'd1;
			else
				stat_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load)
			word_q <= burst.word;
		else if (take && nbytes_q != 2'd0)
			word_q <= {word_q[15:0], 8'd0};
	end

	`B64D_ASSERT_NOW(a_status_ends_run, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
	`B64D_ASSERT_NOW(a_bad_only_status, m_axis_tvalid && !m_axis_tuser[0], !m_axis_tuser[1])
	`B64D_ASSERT_NEXT(a_drain_one, take && !(load && can_load), total == $past(total) - 3'd1)

endmodule

// ===== hdl/base64_stream_decoder.sv =====
// Base64 stream decoder (standard alphabet, '=' padding).
// Input channel s_axis: one ASCII character per transfer in tdata[7:0]; tlast
// marks the last character of a text. Output channel m_axis: one result per
// transfer, data byte in tdata[7:0], tuser[0] set for the end-of-text status,
// tuser[1] set on that status when the text was invalid, tlast on the last
// result caused by one input character.
// An accepted character is registered in the input register, decoded from there
// combinationally, and its results are loaded into the output register.
// Throughput: one character per cycle. Characters that yield no result pass
// the decoder even while earlier results drain. A character that closes a
// quartet waits in the input register until the output register is free or
// its last pending result is being transferred; its bundle then holds the
// output register until its results (up to three bytes, four with the status)
// leave; with tready high a well-formed text streams one character per cycle.
// When m_axis_tready is low, results hold in the output register and
// s_axis_tready drops once a character that yields results waits in the
// input register.
// Reset (arst_n low) empties both registers and clears the quartet state;
// after the status result of a text the decoder is ready for the next text.
module base64_stream_decoder import b64d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] text_char
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] data_byte
	output logic [1:0] m_axis_tuser,   // [0] is_status, [1] bad_input
	output logic       m_axis_tlast
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        final_s1;
	logic        can_load;
	logic        step;
	logic        emits;
	b64d_burst_t burst;

	// A character with no result never waits for the output register.
	assign emits = burst.nbytes != 2'd0 || burst.status;
	assign step = valid_s1 && (can_load || !emits);
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
		end
	end

	b64d_quartet u_quartet (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.text_char  (char_s1),
		.final_char (final_s1),
		.burst      (burst)
	);

	b64d_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && emits),
		.burst         (burst),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
